[rtl/core/dms_pkg.sv]
// ============================================================================
// dms_pkg
// Shared types, codes and reset constants of the display mode sequencer.
// ============================================================================
package dms_pkg;

    localparam int TIMER_W   = 17;
    localparam int COUNT_W   = 16;
    localparam int ALERT_W   = 8;
    localparam int OP_W      = 4;
    localparam int CFG_IDX_W = 3;

    typedef logic [TIMER_W-1:0] timer_t;

    localparam timer_t TIMER_MAX = '1;

    // event operation codes; 9..15 are show requests
    localparam logic [OP_W-1:0] OP_TICK       = 4'd0;
    localparam logic [OP_W-1:0] OP_SYNC       = 4'd1;
    localparam logic [OP_W-1:0] OP_ALERT      = 4'd2;
    localparam logic [OP_W-1:0] OP_ALERT_BARE = 4'd3;
    localparam logic [OP_W-1:0] OP_CANCEL     = 4'd4;
    localparam logic [OP_W-1:0] OP_OTHER      = 4'd5;
    localparam logic [OP_W-1:0] OP_EMG_ON     = 4'd6;
    localparam logic [OP_W-1:0] OP_EMG_OFF    = 4'd7;
    localparam logic [OP_W-1:0] OP_CLEAR      = 4'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALERT_HOLD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DT_HOLD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DT_REFRESH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EMG_NOTICE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EMG_CLEARED  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CLR_NOTICE   = 3'd6;

    localparam timer_t RST_IDLE_TIMEOUT = 17'd40000;
    localparam timer_t RST_ALERT_HOLD   = 17'd10000;
    localparam timer_t RST_DT_HOLD      = 17'd15000;
    localparam timer_t RST_DT_REFRESH   = 17'd500;
    localparam timer_t RST_EMG_NOTICE   = 17'd5000;
    localparam timer_t RST_EMG_CLEARED  = 17'd5000;
    localparam timer_t RST_CLR_NOTICE   = 17'd3000;

    typedef enum logic [2:0] {
        MODE_COUNT       = 3'd0,
        MODE_ALERT       = 3'd1,
        MODE_DATETIME    = 3'd2,
        MODE_EMG_SENT    = 3'd3,
        MODE_EMG_ACTIVE  = 3'd4,
        MODE_EMG_CLEARED = 3'd5,
        MODE_ALL_CLEARED = 3'd6
    } mode_t;

    typedef enum logic [2:0] {
        CMD_NONE        = 3'd0,
        CMD_COUNT       = 3'd1,
        CMD_ALERT       = 3'd2,
        CMD_DATETIME    = 3'd3,
        CMD_EMG_SENT    = 3'd4,
        CMD_EMG_ACTIVE  = 3'd5,
        CMD_EMG_CLEARED = 3'd6,
        CMD_ALL_CLEARED = 3'd7
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [COUNT_W-1:0] new_count;
        logic [ALERT_W-1:0] alert_handle;
    } event_t;

    typedef struct packed {
        logic [2:0]         display_command;
        logic [COUNT_W-1:0] shown_count;
        logic [ALERT_W-1:0] shown_alert;
        logic [2:0]         current_mode;
        logic               first_message_seen;
    } result_t;

    typedef struct packed {
        timer_t idle_timeout;
        timer_t alert_hold;
        timer_t dt_hold;
        timer_t dt_refresh;
        timer_t emg_notice;
        timer_t emg_cleared;
        timer_t clr_notice;
    } cfg_t;

    function automatic timer_t sat_inc(input timer_t v);
        sat_inc = (v == TIMER_MAX) ? v : v + timer_t'(1);
    endfunction

endpackage

[rtl/core/dms_cfg_regs.sv]
// ============================================================================
// dms_cfg_regs
// Configuration register file, one write per cycle, indexes past the list
// are dropped.
// ============================================================================
module dms_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [dms_pkg::CFG_IDX_W-1:0]   wr_index,
    input  dms_pkg::timer_t                 wr_data,
    output dms_pkg::cfg_t                   cfg
);
    import dms_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_IDLE_TIMEOUT: cfg_next.idle_timeout = wr_data;
                REG_ALERT_HOLD:   cfg_next.alert_hold   = wr_data;
                REG_DT_HOLD:      cfg_next.dt_hold      = wr_data;
                REG_DT_REFRESH:   cfg_next.dt_refresh   = wr_data;
                REG_EMG_NOTICE:   cfg_next.emg_notice   = wr_data;
                REG_EMG_CLEARED:  cfg_next.emg_cleared  = wr_data;
                REG_CLR_NOTICE:   cfg_next.clr_notice   = wr_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_timeout <= RST_IDLE_TIMEOUT;
            cfg_reg.alert_hold   <= RST_ALERT_HOLD;
            cfg_reg.dt_hold      <= RST_DT_HOLD;
            cfg_reg.dt_refresh   <= RST_DT_REFRESH;
            cfg_reg.emg_notice   <= RST_EMG_NOTICE;
            cfg_reg.emg_cleared  <= RST_EMG_CLEARED;
            cfg_reg.clr_notice   <= RST_CLR_NOTICE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/dms_in_stage.sv]
// ============================================================================
// dms_in_stage
// Input register: holds one event word until the engine takes it.
// ============================================================================
module dms_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            event_valid,
    output logic            event_stall,
    input  dms_pkg::event_t event_word,
    input  logic            pop,
    output logic            held_valid,
    output dms_pkg::event_t held_word
);
    import dms_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    event_t word_reg;
    logic   take;

    // stalls only when full and the held word cannot move on
    assign event_stall = valid_reg && !pop;
    assign take        = event_valid && !event_stall;

    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (pop)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            word_reg <= event_word;
    end

    assign held_valid = valid_reg;
    assign held_word  = word_reg;

endmodule

[rtl/core/dms_engine.sv]
// ============================================================================
// dms_engine
// Mode state, pick total and timers; decides one result per event.
// ============================================================================
module dms_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  dms_pkg::event_t  word,
    input  dms_pkg::cfg_t    cfg,
    output dms_pkg::result_t result
);
    import dms_pkg::*;

    mode_t                mode_reg, mode_next;
    logic [COUNT_W-1:0]   pick_reg, pick_next;
    timer_t               idle_reg, idle_next;
    timer_t               phase_reg, phase_next;
    timer_t               refresh_reg, refresh_next;
    logic                 pending_reg, pending_next;
    logic                 seen_reg, seen_next;
    logic [ALERT_W-1:0]   alert_reg, alert_next;

    timer_t               idle_inc, phase_inc, refresh_inc;
    logic                 emg;
    logic                 is_msg;
    cmd_t                 cmd;

    assign idle_inc    = sat_inc(idle_reg);
    assign phase_inc   = sat_inc(phase_reg);
    assign refresh_inc = sat_inc(refresh_reg);
    assign emg         = (mode_reg == MODE_EMG_SENT) || (mode_reg == MODE_EMG_ACTIVE);
    assign is_msg      = (word.operation >= OP_SYNC) && (word.operation <= OP_OTHER);

    always_comb
    begin
        mode_next    = mode_reg;
        pick_next    = pick_reg;
        idle_next    = idle_reg;
        phase_next   = phase_reg;
        refresh_next = refresh_reg;
        pending_next = pending_reg;
        seen_next    = seen_reg;
        alert_next   = alert_reg;
        cmd          = CMD_NONE;

        if (is_msg)
        begin
            idle_next = '0;
            seen_next = 1'b1;
        end

        case (word.operation)
            OP_TICK:
            begin
                idle_next    = idle_inc;
                phase_next   = phase_inc;
                refresh_next = refresh_inc;
                case (mode_reg)
                    MODE_COUNT:
                    begin
                        if (idle_inc > cfg.idle_timeout)
                        begin
                            mode_next    = MODE_DATETIME;
                            phase_next   = '0;
                            pending_next = 1'b1;
                        end
                    end
                    MODE_ALERT:
                    begin
                        if (phase_inc >= cfg.alert_hold)
                        begin
                            mode_next = MODE_COUNT;
                            idle_next = '0;
                            cmd       = CMD_COUNT;
                        end
                    end
                    MODE_DATETIME:
                    begin
                        if (phase_inc >= cfg.dt_hold)
                        begin
                            mode_next = MODE_COUNT;
                            idle_next = '0;
                            cmd       = CMD_COUNT;
                        end
                        else if (pending_reg || (refresh_inc >= cfg.dt_refresh))
                        begin
                            pending_next = 1'b0;
                            refresh_next = '0;
                            cmd          = CMD_DATETIME;
                        end
                    end
                    MODE_EMG_SENT:
                    begin
                        if (phase_inc >= cfg.emg_notice)
                        begin
                            mode_next = MODE_EMG_ACTIVE;
                            cmd       = CMD_EMG_ACTIVE;
                        end
                    end
                    MODE_EMG_CLEARED:
                    begin
                        if (phase_inc >= cfg.emg_cleared)
                        begin
                            mode_next = MODE_COUNT;
                            idle_next = '0;
                            cmd       = CMD_COUNT;
                        end
                    end
                    MODE_ALL_CLEARED:
                    begin
                        if (phase_inc >= cfg.clr_notice)
                        begin
                            mode_next = MODE_COUNT;
                            idle_next = '0;
                            cmd       = CMD_COUNT;
                        end
                    end
                    default:
                    begin
                        cmd = CMD_NONE;   // emergency active holds
                    end
                endcase
            end
            OP_SYNC:
            begin
                pick_next = word.new_count;
                if (mode_reg == MODE_COUNT)
                    cmd = CMD_COUNT;
            end
            OP_ALERT:
            begin
                alert_next = word.alert_handle;
                pick_next  = word.new_count;
                if (!emg)
                begin
                    mode_next  = MODE_ALERT;
                    phase_next = '0;
                    cmd        = CMD_ALERT;
                end
            end
            OP_ALERT_BARE, OP_OTHER:
            begin
                cmd = CMD_NONE;
            end
            OP_CANCEL:
            begin
                pick_next = word.new_count;
                if ((mode_reg == MODE_DATETIME) || (mode_reg == MODE_COUNT))
                begin
                    mode_next = MODE_COUNT;
                    cmd       = CMD_COUNT;
                end
            end
            OP_EMG_ON:
            begin
                mode_next  = MODE_EMG_SENT;
                phase_next = '0;
                cmd        = CMD_EMG_SENT;
            end
            OP_EMG_OFF:
            begin
                if (emg)
                begin
                    mode_next  = MODE_EMG_CLEARED;
                    phase_next = '0;
                    cmd        = CMD_EMG_CLEARED;
                end
            end
            OP_CLEAR:
            begin
                pick_next = '0;
                if (!emg)
                begin
                    mode_next  = MODE_ALL_CLEARED;
                    phase_next = '0;
                    cmd        = CMD_ALL_CLEARED;
                end
            end
            default:
            begin
                // show request
                if (mode_reg == MODE_COUNT)
                    cmd = CMD_COUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_COUNT;
            pick_reg    <= '0;
            idle_reg    <= '0;
            phase_reg   <= '0;
            refresh_reg <= '0;
            pending_reg <= 1'b0;
            seen_reg    <= 1'b0;
            alert_reg   <= '0;
        end
        else if (fire)
        begin
            mode_reg    <= mode_next;
            pick_reg    <= pick_next;
            idle_reg    <= idle_next;
            phase_reg   <= phase_next;
            refresh_reg <= refresh_next;
            pending_reg <= pending_next;
            seen_reg    <= seen_next;
            alert_reg   <= alert_next;
        end
    end

    always_comb
    begin
        result.display_command    = cmd;
        result.shown_count        = pick_next;
        result.shown_alert        = alert_next;
        result.current_mode       = mode_next;
        result.first_message_seen = seen_next;
    end

endmodule

[rtl/core/dms_out_stage.sv]
// ============================================================================
// dms_out_stage
// Result register: holds one command word until the sink takes it.
// ============================================================================
module dms_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  dms_pkg::result_t load_word,
    output logic             room,
    output logic             cmd_valid,
    input  logic             cmd_stall,
    output dms_pkg::result_t cmd_word
);
    import dms_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t word_reg;

    // free now, or the held word leaves at this edge
    assign room = !valid_reg || !cmd_stall;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (cmd_stall)
            valid_next = valid_reg;
        else
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            word_reg <= load_word;
    end

    assign cmd_valid = valid_reg;
    assign cmd_word  = word_reg;

endmodule

[rtl/core/display_mode_sequencer.sv]
// ============================================================================
// display_mode_sequencer
// Seven-mode display sequencer: one display command word per event word.
// ============================================================================
//
//  channel   signals                                  dir  word
//  -------   ---------------------------------------  ---  -------------------
//  event     event_valid, event_stall, event_word     in   dms_pkg::event_t
//  command   cmd_valid, cmd_stall, cmd_word           out  dms_pkg::result_t
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in  17-bit ms register
//
//  - One event word per cycle, sustained while cmd_stall is low. An event word
//    taken into the input register is decided into the result register as
//    soon as that register has room; its command word then shows on cmd_valid.
//  - The single decision stage updates the mode and timer state, so each
//    event sees the state left by the one before it with no gaps.
//  - cmd_stall holds the result register; the input register keeps taking
//    words as long as the held word can move on, so event_stall rises only
//    when both registers are full.
//  - rst_n clears both valid flags and all sequencer state asynchronously;
//    config returns to its defaults. cfg_ready is always high.
//
module display_mode_sequencer (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            event_valid,
    output logic                            event_stall,
    input  dms_pkg::event_t                 event_word,

    output logic                            cmd_valid,
    input  logic                            cmd_stall,
    output dms_pkg::result_t                cmd_word,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  dms_pkg::timer_t                 cfg_data
);
    import dms_pkg::*;

    cfg_t    cfg;
    logic    held_valid;
    event_t  held_word;
    logic    room;
    logic    advance;
    result_t result;

    // config writes are never refused
    assign cfg_ready = 1'b1;

    dms_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    dms_in_stage u_in (
        .clk         (clk),
        .rst_n       (rst_n),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_word  (event_word),
        .pop         (advance),
        .held_valid  (held_valid),
        .held_word   (held_word)
    );

    // the held event is processed exactly when the result register can take it
    assign advance = held_valid && room;

    dms_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .word   (held_word),
        .cfg    (cfg),
        .result (result)
    );

    dms_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .load_word (result),
        .room      (room),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word)
    );

endmodule

[rtl/core/dms_checker.sv]
// ============================================================================
// dms_checker
// Port-level checks of the display mode sequencer, bound to the top level.
// ============================================================================
module dms_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             event_stall,
    input  logic             cmd_valid,
    input  logic             cmd_stall,
    input  dms_pkg::result_t cmd_word
);
    import dms_pkg::*;

    logic seen_reg;
    logic seen_next;

    // remembers a delivered word with the first-message flag set
    assign seen_next = seen_reg ||
                       (cmd_valid && !cmd_stall && cmd_word.first_message_seen);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= 1'b0;
        else
            seen_reg <= seen_next;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd_word))
        else $error("stalled command word changed");

    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_valid |-> !event_stall)
        else $error("event stalled with empty result register");

    a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && seen_reg |-> cmd_word.first_message_seen)
        else $error("first message flag dropped");

    a_cmd_mode: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |->
            (cmd_word.display_command != CMD_COUNT
                || cmd_word.current_mode == MODE_COUNT)
            && (cmd_word.display_command != CMD_ALERT
                || cmd_word.current_mode == MODE_ALERT)
            && (cmd_word.display_command != CMD_DATETIME
                || cmd_word.current_mode == MODE_DATETIME)
            && (cmd_word.display_command != CMD_EMG_SENT
                || cmd_word.current_mode == MODE_EMG_SENT)
            && (cmd_word.display_command != CMD_EMG_ACTIVE
                || cmd_word.current_mode == MODE_EMG_ACTIVE)
            && (cmd_word.display_command != CMD_EMG_CLEARED
                || cmd_word.current_mode == MODE_EMG_CLEARED))
        else $error("command does not match mode");

    a_cleared_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_word.display_command == CMD_ALL_CLEARED
            |-> cmd_word.current_mode == MODE_ALL_CLEARED && cmd_word.shown_count == '0)
        else $error("all-cleared word with nonzero count");

endmodule

bind display_mode_sequencer dms_checker u_dms_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .event_stall (event_stall),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd_word    (cmd_word)
);

[tb/display_mode_sequencer_test.sv]
// ============================================================================
// display_mode_sequencer_test
// Self-checking bench for the display mode sequencer. A scoreboard predicts
// one command word per accepted event word, and each command word the block
// sends is checked field by field. The run covers directed corner events,
// several timing register sets (zero, small, full range and maximum) and a
// tick run against the idle limit. Both channels see random stalls.
// ============================================================================
`timescale 1ns / 100ps

module display_mode_sequencer_test;

    import dms_pkg::*;

    // show requests occupy the upper operation codes
    localparam logic [OP_W-1:0]      OP_SHOW_LO    = 4'd9;
    localparam logic [OP_W-1:0]      OP_SHOW_MID   = 4'd12;
    localparam logic [OP_W-1:0]      OP_SHOW_HI    = 4'd15;
    // index past the last register; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    localparam int HOLD_OFF_CYCLES = 120;      // long receiver stall
    localparam int SETTLE_CYCLES   = 8;        // pause once every owed word is back
    localparam int TICK_RUN        = 20;       // ticks against the top idle limit

    // ------------------------------------------------------------------------
    // Scoreboard: a predictor of the sequencer plus the queue of command words
    // it still owes.
    // ------------------------------------------------------------------------
    class mode_scoreboard;
        timer_t idle_limit, alert_hold, dt_hold, dt_refresh;
        timer_t emg_notice, emg_clear_hold, clr_hold;

        mode_t               view;
        logic [COUNT_W-1:0]  picks;
        timer_t              idle_ms, phase_ms, refresh_ms;
        bit                  redraw_due;
        bit                  seen;
        logic [ALERT_W-1:0]  alert_tag;

        result_t pending_cmds[$];
        int      fail_count;

        function new();
            idle_limit     = RST_IDLE_TIMEOUT;
            alert_hold     = RST_ALERT_HOLD;
            dt_hold        = RST_DT_HOLD;
            dt_refresh     = RST_DT_REFRESH;
            emg_notice     = RST_EMG_NOTICE;
            emg_clear_hold = RST_EMG_CLEARED;
            clr_hold       = RST_CLR_NOTICE;
            view           = MODE_COUNT;
            picks          = '0;
            idle_ms        = '0;
            phase_ms       = '0;
            refresh_ms     = '0;
            redraw_due     = 1'b0;
            seen           = 1'b0;
            alert_tag      = '0;
            fail_count     = 0;
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            fail_count++;
        endtask

        function void set_reg(logic [CFG_IDX_W-1:0] idx, timer_t val);
            case (idx)
                REG_IDLE_TIMEOUT: idle_limit     = val;
                REG_ALERT_HOLD:   alert_hold     = val;
                REG_DT_HOLD:      dt_hold        = val;
                REG_DT_REFRESH:   dt_refresh     = val;
                REG_EMG_NOTICE:   emg_notice     = val;
                REG_EMG_CLEARED:  emg_clear_hold = val;
                REG_CLR_NOTICE:   clr_hold       = val;
                default: ;
            endcase
        endfunction

        function int waiting();
            return pending_cmds.size();
        endfunction

        function timer_t bump(timer_t v);
            return (v == {TIMER_W{1'b1}}) ? v : v + 1'b1;
        endfunction

        function bit emergency();
            return view == MODE_EMG_SENT || view == MODE_EMG_ACTIVE;
        endfunction

        function cmd_t return_to_count();
            view    = MODE_COUNT;
            idle_ms = '0;
            return CMD_COUNT;
        endfunction

        // one millisecond: timers move first, then the mode is judged
        function cmd_t advance_ms();
            cmd_t cmd;
            cmd        = CMD_NONE;
            idle_ms    = bump(idle_ms);
            phase_ms   = bump(phase_ms);
            refresh_ms = bump(refresh_ms);
            case (view)
                MODE_COUNT:
                    if (idle_ms > idle_limit) begin
                        view       = MODE_DATETIME;
                        phase_ms   = '0;
                        redraw_due = 1'b1;
                    end
                MODE_ALERT:
                    if (phase_ms >= alert_hold) cmd = return_to_count();
                MODE_DATETIME:
                    if (phase_ms >= dt_hold)
                        cmd = return_to_count();
                    else if (redraw_due || refresh_ms >= dt_refresh) begin
                        redraw_due = 1'b0;
                        refresh_ms = '0;
                        cmd        = CMD_DATETIME;
                    end
                MODE_EMG_SENT:
                    if (phase_ms >= emg_notice) begin
                        view = MODE_EMG_ACTIVE;
                        cmd  = CMD_EMG_ACTIVE;
                    end
                MODE_EMG_CLEARED:
                    if (phase_ms >= emg_clear_hold) cmd = return_to_count();
                MODE_ALL_CLEARED:
                    if (phase_ms >= clr_hold) cmd = return_to_count();
                default: ;
            endcase
            return cmd;
        endfunction

        function void predict_command(event_t ev);
            cmd_t    cmd;
            result_t want;
            cmd = CMD_NONE;
            if (ev.operation >= OP_SYNC && ev.operation <= OP_OTHER) begin
                idle_ms = '0;
                seen    = 1'b1;
            end
            case (ev.operation)
                OP_TICK: cmd = advance_ms();
                OP_SYNC:
                begin
                    picks = ev.new_count;
                    if (view == MODE_COUNT) cmd = CMD_COUNT;
                end
                OP_ALERT:
                begin
                    alert_tag = ev.alert_handle;
                    picks     = ev.new_count;
                    if (!emergency()) begin
                        view     = MODE_ALERT;
                        phase_ms = '0;
                        cmd      = CMD_ALERT;
                    end
                end
                OP_ALERT_BARE, OP_OTHER: ;
                OP_CANCEL:
                begin
                    picks = ev.new_count;
                    if (view == MODE_DATETIME || view == MODE_COUNT) begin
                        view = MODE_COUNT;
                        cmd  = CMD_COUNT;
                    end
                end
                OP_EMG_ON:
                begin
                    view     = MODE_EMG_SENT;
                    phase_ms = '0;
                    cmd      = CMD_EMG_SENT;
                end
                OP_EMG_OFF:
                    if (emergency()) begin
                        view     = MODE_EMG_CLEARED;
                        phase_ms = '0;
                        cmd      = CMD_EMG_CLEARED;
                    end
                OP_CLEAR:
                begin
                    picks = '0;
                    if (!emergency()) begin
                        view     = MODE_ALL_CLEARED;
                        phase_ms = '0;
                        cmd      = CMD_ALL_CLEARED;
                    end
                end
                default:
                    if (view == MODE_COUNT) cmd = CMD_COUNT;
            endcase
            want.display_command    = cmd;
            want.shown_count        = picks;
            want.shown_alert        = alert_tag;
            want.current_mode       = view;
            want.first_message_seen = seen;
            pending_cmds.push_back(want);
        endfunction

        task check_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                report($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check_command(result_t got);
            result_t want;
            if (pending_cmds.size() == 0) begin
                report("command word with no event outstanding");
                return;
            end
            want = pending_cmds.pop_front();
            check_field("display_command", got.display_command, want.display_command);
            check_field("shown_count", got.shown_count, want.shown_count);
            check_field("shown_alert", got.shown_alert, want.shown_alert);
            check_field("current_mode", got.current_mode, want.current_mode);
            check_field("first_message_seen", got.first_message_seen,
                        want.first_message_seen);
        endtask

        task check_drained();
            if (pending_cmds.size() != 0)
                report($sformatf("%0d command words never arrived", pending_cmds.size()));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   event_valid = 1'b0;
    logic                   event_stall;
    event_t                 event_word  = '0;
    logic                   cmd_valid;
    logic                   cmd_stall   = 1'b0;
    result_t                cmd_word;
    logic                   cfg_valid   = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index   = '0;
    timer_t                 cfg_data    = '0;

    mode_scoreboard board;

    bit valid_on;        // mirrors event_valid so it is never lowered twice in a step
    bit quiet;           // no random stalls on either side
    bit hold_off_req;    // asks the command sink for one long stall

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    display_mode_sequencer u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_word  (event_word),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd_word    (cmd_word),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Monitor: both handshakes are sampled at the same edge, the event first,
    // so a prediction is always queued before any word that could answer it.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (event_valid && !event_stall) board.predict_command(event_word);
            if (cmd_valid && !cmd_stall)     board.check_command(cmd_word);
        end
    end

    // ------------------------------------------------------------------------
    // Command sink: random stall bursts plus one long hold-off on request. Its
    // stall counter lives here, not in the sender.
    // ------------------------------------------------------------------------
    initial
    begin : cmd_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                stall_left   = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            if (stall_left == 0 && !quiet && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 16);
            if (stall_left > 0) begin
                cmd_stall <= 1'b1;
                stall_left--;
            end
            else begin
                cmd_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Event and config drivers
    // ------------------------------------------------------------------------
    function automatic event_t make_event(logic [OP_W-1:0] op, logic [COUNT_W-1:0] cnt,
                                          logic [ALERT_W-1:0] handle);
        event_t ev;
        ev.operation    = op;
        ev.new_count    = cnt;
        ev.alert_handle = handle;
        return ev;
    endfunction

    // counts lean toward the extremes now and then
    function automatic logic [COUNT_W-1:0] rand_count();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return COUNT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [ALERT_W-1:0] rand_handle();
        return ALERT_W'($urandom_range(0, 255));
    endfunction

    function automatic timer_t rand_timer(input int unsigned lo, input int unsigned hi);
        return timer_t'($urandom_range(lo, hi));
    endfunction

    // ticks dominate so the hold timers actually expire between messages
    function automatic event_t random_event();
        int                roll;
        logic [OP_W-1:0]   op;
        roll = $urandom_range(0, 99);
        if      (roll < 55) op = OP_TICK;
        else if (roll < 62) op = OP_SYNC;
        else if (roll < 68) op = OP_ALERT;
        else if (roll < 71) op = OP_ALERT_BARE;
        else if (roll < 75) op = OP_CANCEL;
        else if (roll < 78) op = OP_OTHER;
        else if (roll < 83) op = OP_EMG_ON;
        else if (roll < 89) op = OP_EMG_OFF;
        else if (roll < 93) op = OP_CLEAR;
        else                op = OP_W'($urandom_range(OP_SHOW_LO, OP_SHOW_HI));
        return make_event(op, rand_count(), rand_handle());
    endfunction

    // Holds the word until accepted; valid stays up into the next word unless
    // a random gap is drawn.
    task automatic send_event(input event_t ev);
        event_word  <= ev;
        event_valid <= 1'b1;
        valid_on     = 1'b1;
        @(posedge clk);
        while (event_stall) @(posedge clk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            event_valid <= 1'b0;
            valid_on     = 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++) send_event(random_event());
    endtask

    // sender stops until every owed command word is back, then waits SETTLE_CYCLES more
    task automatic settle();
        if (valid_on) begin
            event_valid <= 1'b0;
            valid_on     = 1'b0;
        end
        do @(posedge clk); while (board.waiting() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input timer_t val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.set_reg(idx, val);
    endtask

    // only called with the block idle
    task automatic load_timing(input timer_t idle, input timer_t alert, input timer_t dth,
                               input timer_t dtr, input timer_t notice,
                               input timer_t emg_clr, input timer_t clr);
        write_reg(REG_IDLE_TIMEOUT, idle);
        write_reg(REG_ALERT_HOLD, alert);
        write_reg(REG_DT_HOLD, dth);
        write_reg(REG_DT_REFRESH, dtr);
        write_reg(REG_EMG_NOTICE, notice);
        write_reg(REG_EMG_CLEARED, emg_clr);
        write_reg(REG_CLR_NOTICE, clr);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_small_timing();
        load_timing(rand_timer(0, 40), rand_timer(0, 24), rand_timer(0, 30),
                    rand_timer(1, 8), rand_timer(0, 20), rand_timer(0, 20),
                    rand_timer(0, 20));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        board        = new();
        valid_on     = 1'b0;
        quiet        = 1'b0;
        hold_off_req = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners, still on the reset timing values.
        send_event(make_event(OP_SHOW_LO, '0, '0));          // show in count view
        send_event(make_event(OP_EMG_OFF, '1, '1));          // emergency off, none active
        send_event(make_event(OP_TICK, '0, '0));
        send_event(make_event(OP_SYNC, '1, '0));             // first message, top count
        send_event(make_event(OP_ALERT, '0, '1));            // alert, top handle
        send_event(make_event(OP_SHOW_HI, '1, '1));          // show outside count view
        send_event(make_event(OP_CANCEL, 16'h1234, 8'h00));  // cancel during alert
        send_event(make_event(OP_EMG_ON, '0, '0));
        send_event(make_event(OP_ALERT, 16'hAAAA, 8'h5A));   // alert swallowed by emergency
        send_event(make_event(OP_CANCEL, 16'h5555, 8'hA5));  // cancel during emergency
        send_event(make_event(OP_CLEAR, '1, '1));            // clear during emergency
        send_event(make_event(OP_EMG_ON, '1, '0));           // re-arm while already sent
        send_event(make_event(OP_EMG_OFF, '0, '0));
        send_event(make_event(OP_CLEAR, '0, '0));
        send_event(make_event(OP_ALERT_BARE, '1, '1));
        send_event(make_event(OP_OTHER, '1, '1));
        send_event(make_event(OP_TICK, '1, '1));
        send_event(make_event(OP_SHOW_MID, '0, '1));
        send_event(make_event(OP_SYNC, 16'h5555, 8'h00));    // sync outside count view
        settle();

        // Zero holds and zero refresh: every view but emergency active ends on its first tick.
        load_timing('0, '0, '0, '0, '0, '0, '0);
        run_random(150);
        settle();

        // Small timing sets so every mode is reached and left often.
        load_small_timing();
        run_random(120);
        settle();                    // sender waits for every owed word mid-set
        run_random(80);
        settle();

        load_small_timing();
        hold_off_req = 1'b1;         // sink stalls long, sender keeps pushing
        run_random(150);
        settle();

        load_small_timing();
        run_random(150);
        settle();

        load_timing(17'd3, 17'd2, 17'd12, 17'd1, 17'd3, 17'd2, 17'd1);
        run_random(150);
        settle();

        // Full-range random values, then the maximum everywhere.
        load_timing(rand_timer(0, 131071), rand_timer(0, 131071),
                    rand_timer(0, 131071), rand_timer(0, 131071),
                    rand_timer(0, 131071), rand_timer(0, 131071),
                    rand_timer(0, 131071));
        run_random(100);
        settle();

        load_timing('1, '1, '1, '1, '1, '1, '1);
        write_reg(CFG_IDX_SPARE, 17'h1ABCD);                 // unmapped index, no effect
        cfg_valid <= 1'b0;
        @(posedge clk);
        run_random(60);
        settle();

        // Idle limit at its top value: a tick run leaves count view alone;
        // dropping the limit below the idle time then switches the view to
        // date/time on the next tick.
        quiet = 1'b1;
        load_timing('1, '0, '0, '0, '0, '0, '0);
        send_event(make_event(OP_EMG_ON, rand_count(), rand_handle()));
        send_event(make_event(OP_EMG_OFF, rand_count(), rand_handle()));
        for (int i = 0; i < TICK_RUN; i++)
            send_event(make_event(OP_TICK, rand_count(), rand_handle()));
        settle();
        write_reg(REG_IDLE_TIMEOUT, 17'd1);
        cfg_valid <= 1'b0;
        @(posedge clk);
        repeat (3) send_event(make_event(OP_TICK, '0, '0));
        settle();

        // Closing stretch at full rate with no stalls on either side.
        load_small_timing();
        run_random(200);
        settle();

        board.check_drained();
        if (board.fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
